[src/csp_pkg.sv]
// Package for the cardinal spline point evaluator.
// Holds sizes, fixed-point constants and the sequencer state type; no dependencies.
`default_nettype none
package csp_pkg;
  localparam int POINT_DEPTH = 64;
  localparam int IDX_W       = $clog2(POINT_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int COORD_BITS  = 16;
  localparam int W_BITS      = 17;
  localparam int FR_BITS     = 17;
  localparam int D_BITS      = 20;
  localparam int MA_BITS     = 21;
  localparam int MB_BITS     = 18;
  localparam int MP_BITS     = MA_BITS + MB_BITS;
  localparam int V_BITS      = 40;
  localparam int DIFF_BITS   = V_BITS + 1;
  localparam int LO_BITS     = 20;
  localparam int ACC_BITS    = 60;
  localparam int DIV_BITS    = 40;
  localparam int DIV_STEPS   = DIV_BITS / 8;
  localparam int OFF_SHIFT   = 35;
  localparam logic [W_BITS-1:0] ONE_Q16 = W_BITS'(65536);

  localparam logic ADDR_COUNT   = 1'b0;
  localparam logic ADDR_TENSION = 1'b1;
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_EVAL     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DIV_START, ST_DIV_WAIT, ST_SETUP,
    ST_L_DIFF, ST_L_LO, ST_L_HI, ST_L_ACC, ST_L_ADD, ST_FINISH, ST_EMIT
  } state_e;
endpackage
`default_nettype wire

[src/csp_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on csp_pkg for operand widths.
`default_nettype none
module csp_mul (
  input  wire                                  clk_i,
  input  wire logic signed [csp_pkg::MA_BITS-1:0] a_i,
  input  wire logic signed [csp_pkg::MB_BITS-1:0] b_i,
  output logic signed [csp_pkg::MP_BITS-1:0]      p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule
`default_nettype wire

[src/csp_div3.sv]
// Iterative floor divide by three of an unsigned word, eight bits per cycle.
// Depends on csp_pkg for the word width and step count.
`default_nettype none
module csp_div3 (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire logic [csp_pkg::DIV_BITS-1:0]    num_i,
  output logic                                 done_o,
  output logic [csp_pkg::DIV_BITS-1:0]         quo_o
);
  logic [csp_pkg::DIV_BITS-1:0] sh_q, sh_d;
  logic [1:0] rem_q, rem_d;
  logic [2:0] cnt_q;
  logic busy_q, done_q;

  always_comb begin
    logic [2:0] t;
    logic [7:0] qb;
    logic [1:0] r;
    r = rem_q;
    qb = '0;
    for (int j = 7; j >= 0; j--) begin
      t = {r, sh_q[csp_pkg::DIV_BITS-8+j]};
      qb[j] = (t >= 3'd3);
      r = qb[j] ? 2'(t - 3'd3) : t[1:0];
    end
    rem_d = r;
    sh_d = {sh_q[csp_pkg::DIV_BITS-9:0], qb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'(csp_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
endmodule
`default_nettype wire

[src/cardinal_spline_point_eval_top.sv]
// Cardinal spline point evaluator: point table, APB registers and sequencer.
// Depends on csp_pkg, csp_mul and csp_div3.
//
// A write beat stores one point, and write beats can follow back to back. An evaluate beat
// whose segment is out of range gives a zero result through the emit state. An in-range
// evaluate reads the four points from the one-port point table, then per axis computes two
// tangent offsets (one pass each through the shared 21x18 multiplier and the divide-by-three
// unit, none with exactly two points), a setup step, six de Casteljau lerps (one with exactly
// two points) through the diff, low, high, accumulate and add states on that same multiplier
// and a rounding step, and last loads the output register. The input is not ready while an
// item is in work and comes back as the result is loaded; a finished result waits in the
// output register without blocking the next beat's acceptance, but a second result waits
// for the first.
`default_nettype none
module cardinal_spline_point_eval_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // point_index[5:0], coord_x[21:6], coord_y[37:22], weight[54:38], zero[55]
  input  wire  [55:0] s_axis_tdata,
  // command[0]
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // curve_x[15:0], curve_y[31:16]
  output logic [31:0] m_axis_tdata,
  // segment_valid[0]
  output logic        m_axis_tuser,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int CB = csp_pkg::COORD_BITS;

  csp_pkg::state_e state_q, state_d;

  logic [csp_pkg::CNT_W-1:0] pc_q, n_eff;
  logic signed [CB-1:0] tension_q;

  logic [2*CB-1:0] mem [csp_pkg::POINT_DEPTH];
  logic [2*CB-1:0] rd_q;
  logic [csp_pkg::IDX_W-1:0] raddr;

  logic [csp_pkg::IDX_W-1:0] seg_q;
  logic [csp_pkg::W_BITS-1:0] w_q;
  logic lin_q, first_q, last_q, axis_q, tsel_q;
  logic [2:0] rcnt_q, lstep_q;
  logic signed [CB-1:0] px_q [4];
  logic signed [CB-1:0] py_q [4];
  logic signed [csp_pkg::V_BITS-1:0] v_q [4];
  logic signed [csp_pkg::V_BITS-1:0] off_q [2];
  logic signed [csp_pkg::DIFF_BITS-1:0] diff_q;
  logic signed [csp_pkg::ACC_BITS-1:0] acc_q;
  logic signed [CB-1:0] res_x_q, res_y_q;
  logic res_v_q;
  logic out_v_q;
  logic [2*CB-1:0] out_d_q;
  logic out_u_q;

  logic accept, cfg_wr, out_free;
  logic [csp_pkg::W_BITS-1:0] w_in;
  logic [csp_pkg::IDX_W-1:0] in_idx;
  logic seg_ok;
  logic [1:0] k;
  logic lerp_last;
  logic signed [CB-1:0] ps [4];
  logic signed [csp_pkg::D_BITS-1:0] d0, d1, dsel;
  logic signed [csp_pkg::FR_BITS-1:0] fr;
  logic signed [csp_pkg::MA_BITS-1:0] mul_a;
  logic signed [csp_pkg::MB_BITS-1:0] mul_b;
  logic signed [csp_pkg::MP_BITS-1:0] mul_p;
  logic div_start, div_done;
  logic [csp_pkg::DIV_BITS-1:0] div_num, div_quo;
  logic signed [csp_pkg::DIV_BITS-1:0] x2;
  logic signed [csp_pkg::V_BITS:0] rnd;
  logic signed [CB-1:0] sat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_v_q || m_axis_tready;
  assign n_eff    = (pc_q > csp_pkg::CNT_W'(csp_pkg::POINT_DEPTH))
                  ? csp_pkg::CNT_W'(csp_pkg::POINT_DEPTH) : pc_q;
  assign in_idx   = s_axis_tdata[5:0];
  assign w_in     = (s_axis_tdata[54:38] > csp_pkg::ONE_Q16) ? csp_pkg::ONE_Q16
                  : s_axis_tdata[54:38];
  assign seg_ok   = (n_eff >= csp_pkg::CNT_W'(2))
                 && (csp_pkg::CNT_W'(in_idx) < n_eff - csp_pkg::CNT_W'(1));

  always_comb begin
    case (paddr[2])
      csp_pkg::ADDR_COUNT: prdata = {25'd0, pc_q};
      default:             prdata = {{16{tension_q[CB-1]}}, tension_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      tension_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        csp_pkg::ADDR_COUNT: pc_q      <= pwdata[6:0];
        default:             tension_q <= pwdata[15:0];
      endcase
    end
  end

  // point table
  assign raddr = seg_q - csp_pkg::IDX_W'(1) + csp_pkg::IDX_W'(rcnt_q[1:0]);
  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser == csp_pkg::CMD_WRITE
        && csp_pkg::CNT_W'(in_idx) < n_eff) begin
      mem[in_idx] <= {s_axis_tdata[37:22], s_axis_tdata[21:6]};
    end
    rd_q <= mem[raddr];
  end

  // tangent differences; slots hold points s-1, s, s+1, s+2
  always_comb begin
    for (int i = 0; i < 4; i++) ps[i] = axis_q ? py_q[i] : px_q[i];
    d0 = first_q
       ? (-csp_pkg::D_BITS'(ps[3]) + (csp_pkg::D_BITS'(ps[2]) <<< 2)
          - csp_pkg::D_BITS'(3) * csp_pkg::D_BITS'(ps[1]))
       : (csp_pkg::D_BITS'(ps[2]) - csp_pkg::D_BITS'(ps[0]));
    d1 = last_q
       ? (csp_pkg::D_BITS'(3) * csp_pkg::D_BITS'(ps[2]) - (csp_pkg::D_BITS'(ps[1]) <<< 2)
          + csp_pkg::D_BITS'(ps[0]))
       : (csp_pkg::D_BITS'(ps[3]) - csp_pkg::D_BITS'(ps[1]));
    dsel = tsel_q ? d1 : d0;
    fr = csp_pkg::FR_BITS'(16384) - csp_pkg::FR_BITS'(tension_q);
  end

  always_comb begin
    case (lstep_q)
      3'd1:    k = 2'd1;
      3'd2:    k = 2'd2;
      3'd4:    k = 2'd1;
      default: k = 2'd0;
    endcase
    lerp_last = lin_q || (lstep_q == 3'd5);
  end

  assign x2 = (csp_pkg::DIV_BITS'(mul_p) <<< 1) + csp_pkg::DIV_BITS'(1);
  assign div_num = csp_pkg::DIV_BITS'(x2 + (csp_pkg::DIV_BITS'(3) <<< csp_pkg::OFF_SHIFT));

  assign rnd = (csp_pkg::V_BITS+1)'(v_q[0]) + (csp_pkg::V_BITS+1)'(32768);
  always_comb begin
    logic signed [csp_pkg::V_BITS-15:0] r;
    r = (csp_pkg::V_BITS-14)'(rnd >>> 16);
    if (r > (csp_pkg::V_BITS-14)'(32767))       sat = 16'sh7fff;
    else if (r < -(csp_pkg::V_BITS-14)'(32768)) sat = 16'sh8000;
    else                                        sat = CB'(r);
  end

  csp_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));
  csp_div3 u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .done_o(div_done), .quo_o(div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      csp_pkg::ST_IDLE: begin
        if (accept && s_axis_tuser == csp_pkg::CMD_EVAL) begin
          state_d = seg_ok ? csp_pkg::ST_READ : csp_pkg::ST_EMIT;
        end
      end
      csp_pkg::ST_READ: begin
        if (rcnt_q == 3'd4) state_d = lin_q ? csp_pkg::ST_SETUP : csp_pkg::ST_MUL;
      end
      csp_pkg::ST_MUL:       state_d = csp_pkg::ST_DIV_START;
      csp_pkg::ST_DIV_START: state_d = csp_pkg::ST_DIV_WAIT;
      csp_pkg::ST_DIV_WAIT: begin
        if (div_done) state_d = tsel_q ? csp_pkg::ST_SETUP : csp_pkg::ST_MUL;
      end
      csp_pkg::ST_SETUP:  state_d = csp_pkg::ST_L_DIFF;
      csp_pkg::ST_L_DIFF: state_d = csp_pkg::ST_L_LO;
      csp_pkg::ST_L_LO:   state_d = csp_pkg::ST_L_HI;
      csp_pkg::ST_L_HI:   state_d = csp_pkg::ST_L_ACC;
      csp_pkg::ST_L_ACC:  state_d = csp_pkg::ST_L_ADD;
      csp_pkg::ST_L_ADD:  state_d = lerp_last ? csp_pkg::ST_FINISH : csp_pkg::ST_L_DIFF;
      csp_pkg::ST_FINISH: begin
        if (axis_q) state_d = csp_pkg::ST_EMIT;
        else        state_d = lin_q ? csp_pkg::ST_SETUP : csp_pkg::ST_MUL;
      end
      csp_pkg::ST_EMIT: if (out_free) state_d = csp_pkg::ST_IDLE;
      default: state_d = csp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      csp_pkg::ST_IDLE:      s_axis_tready = 1'b1;
      csp_pkg::ST_MUL: begin
        mul_a = csp_pkg::MA_BITS'(dsel);
        mul_b = csp_pkg::MB_BITS'(fr);
      end
      csp_pkg::ST_DIV_START: div_start = 1'b1;
      csp_pkg::ST_L_LO: begin
        mul_a = {1'b0, diff_q[csp_pkg::LO_BITS-1:0]};
        mul_b = {1'b0, w_q};
      end
      csp_pkg::ST_L_HI: begin
        mul_a = diff_q[csp_pkg::DIFF_BITS-1:csp_pkg::LO_BITS];
        mul_b = {1'b0, w_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csp_pkg::ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == csp_pkg::ST_EMIT && out_free) out_v_q <= 1'b1;
      else if (m_axis_tready)                      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      csp_pkg::ST_IDLE: begin
        seg_q   <= in_idx;
        w_q     <= w_in;
        lin_q   <= (n_eff == csp_pkg::CNT_W'(2));
        first_q <= (in_idx == '0);
        last_q  <= (csp_pkg::CNT_W'(in_idx) + csp_pkg::CNT_W'(2) == n_eff);
        rcnt_q  <= '0;
        axis_q  <= 1'b0;
        tsel_q  <= 1'b0;
        res_x_q <= '0;
        res_y_q <= '0;
        res_v_q <= seg_ok;
      end
      csp_pkg::ST_READ: begin
        rcnt_q <= rcnt_q + 3'd1;
        if (rcnt_q != 3'd0) begin
          px_q[2'(rcnt_q - 3'd1)] <= rd_q[CB-1:0];
          py_q[2'(rcnt_q - 3'd1)] <= rd_q[2*CB-1:CB];
        end
      end
      csp_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          off_q[tsel_q] <= csp_pkg::V_BITS'(div_quo)
                         - (csp_pkg::V_BITS'(1) <<< csp_pkg::OFF_SHIFT);
          tsel_q <= !tsel_q;
        end
      end
      csp_pkg::ST_SETUP: begin
        v_q[0] <= csp_pkg::V_BITS'(ps[1]) <<< 16;
        v_q[3] <= csp_pkg::V_BITS'(ps[2]) <<< 16;
        v_q[1] <= lin_q ? (csp_pkg::V_BITS'(ps[2]) <<< 16)
                        : (csp_pkg::V_BITS'(ps[1]) <<< 16) + off_q[0];
        v_q[2] <= (csp_pkg::V_BITS'(ps[2]) <<< 16) - off_q[1];
        lstep_q <= '0;
      end
      csp_pkg::ST_L_DIFF: begin
        diff_q <= csp_pkg::DIFF_BITS'(v_q[k + 2'd1]) - csp_pkg::DIFF_BITS'(v_q[k]);
      end
      csp_pkg::ST_L_HI:  acc_q <= csp_pkg::ACC_BITS'(mul_p);
      csp_pkg::ST_L_ACC: begin
        acc_q <= acc_q + (csp_pkg::ACC_BITS'(mul_p) <<< csp_pkg::LO_BITS)
               + csp_pkg::ACC_BITS'(32768);
      end
      csp_pkg::ST_L_ADD: begin
        v_q[k]  <= v_q[k] + csp_pkg::V_BITS'(acc_q >>> 16);
        lstep_q <= lstep_q + 3'd1;
      end
      csp_pkg::ST_FINISH: begin
        if (axis_q) res_y_q <= sat;
        else        res_x_q <= sat;
        axis_q <= 1'b1;
      end
      default: ;
    endcase
    if (state_q == csp_pkg::ST_EMIT && out_free) begin
      out_d_q <= {res_y_q, res_x_q};
      out_u_q <= res_v_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = out_u_q;
endmodule
`default_nettype wire

[src/csp_checker.sv]
// Port-level checks for the cardinal spline point evaluator, bound to the top level.
// Depends on cardinal_spline_point_eval_top for its port names.
`default_nettype none
module csp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire        m_axis_tuser,
  input wire        pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("out-of-range segment gave nonzero point");

  a_busy_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input ready right after an evaluate beat");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind cardinal_spline_point_eval_top csp_checker u_csp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
  .pready(pready)
);
`default_nettype wire
